>>> design/lps_pkg.sv
package lps_pkg;

	// request codes carried in the mode field
	typedef enum logic [1:0] {
		MODE_CHECK   = 2'd0,
		MODE_EXEC    = 2'd1,
		MODE_RESTART = 2'd2
	} lps_mode_t;

	localparam int unsigned MODE_W = 2;
	localparam int unsigned STAT_W = 32;
	localparam int unsigned LOOP_W = 32;

	localparam logic [LOOP_W-1:0] LOOP_TIME_RST = 32'd10000;

	// last phase value of each divider, also its reset value
	localparam logic       PH2_LAST  = 1'b1;
	localparam logic [1:0] PH3_LAST  = 2'd2;
	localparam logic [1:0] PH4_LAST  = 2'd3;
	localparam logic [3:0] PH10_LAST = 4'd9;

	typedef struct packed {
		logic due;
		logic second;
		logic third;
		logic fourth;
		logic tenth;
	} lps_flags_t;

	typedef struct packed {
		logic [STAT_W-1:0] period_min;
		logic [STAT_W-1:0] period_max;
		logic [STAT_W-1:0] exec_min;
		logic [STAT_W-1:0] exec_max;
		logic [STAT_W-1:0] first_exec;
	} lps_stats_t;

endpackage

>>> design/lps_core.sv
module lps_core import lps_pkg::*; #(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              upd_en,
	input  logic [MODE_W-1:0] mode,
	input  logic [31:0]       now_us,
	input  logic [LOOP_W-1:0] loop_time,
	output lps_flags_t        flags,
	output lps_stats_t        stats
);

	localparam int unsigned CMP_W = (TIME_WIDTH > LOOP_W) ? TIME_WIDTH : LOOP_W;

	logic [TIME_WIDTH-1:0] now_t;
	logic [TIME_WIDTH-1:0] elapsed;
	logic                  due;

	logic [TIME_WIDTH-1:0] start_q, start_d;
	logic [TIME_WIDTH-1:0] pmin_q, pmin_d;
	logic [TIME_WIDTH-1:0] pmax_q, pmax_d;
	logic [TIME_WIDTH-1:0] emin_q, emin_d;
	logic [TIME_WIDTH-1:0] emax_q, emax_d;
	logic [TIME_WIDTH-1:0] first_q, first_d;
	logic                  ph2_q, ph2_d;
	logic [1:0]            ph3_q, ph3_d;
	logic [1:0]            ph4_q, ph4_d;
	logic [3:0]            ph10_q, ph10_d;

	assign now_t   = TIME_WIDTH'(now_us);
	assign elapsed = now_t - start_q;

	always_comb begin
		start_d = start_q;
		pmin_d  = pmin_q;
		pmax_d  = pmax_q;
		emin_d  = emin_q;
		emax_d  = emax_q;
		first_d = first_q;
		ph2_d   = ph2_q;
		ph3_d   = ph3_q;
		ph4_d   = ph4_q;
		ph10_d  = ph10_q;
		due     = 1'b0;
		case (mode)
			MODE_CHECK: begin
				if (CMP_W'(elapsed) >= CMP_W'(loop_time)) begin
					due     = 1'b1;
					start_d = now_t;
					ph2_d   = (ph2_q >= PH2_LAST) ? 1'b0 : ph2_q + 1'b1;
					ph3_d   = (ph3_q >= PH3_LAST) ? 2'd0 : ph3_q + 2'd1;
					ph4_d   = (ph4_q >= PH4_LAST) ? 2'd0 : ph4_q + 2'd1;
					ph10_d  = (ph10_q >= PH10_LAST) ? 4'd0 : ph10_q + 4'd1;
					if (elapsed < pmin_q) begin
						pmin_d = elapsed;
					end
					if (elapsed > pmax_q) begin
						pmax_d = elapsed;
					end
				end
			end
			MODE_EXEC: begin
				if (elapsed < emin_q) begin
					emin_d = elapsed;
				end
				// first nonzero sample is parked apart from the max
				if (first_q == '0) begin
					first_d = elapsed;
				end else if (elapsed > emax_q) begin
					emax_d = elapsed;
				end
			end
			MODE_RESTART: begin
				start_d = now_t;
				ph2_d   = PH2_LAST;
				ph3_d   = PH3_LAST;
				ph4_d   = PH4_LAST;
				ph10_d  = PH10_LAST;
				pmin_d  = '1;
				pmax_d  = '0;
				emin_d  = '1;
				emax_d  = '0;
				first_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			pmin_q  <= '1;
			pmax_q  <= '0;
			emin_q  <= '1;
			emax_q  <= '0;
			first_q <= '0;
			ph2_q   <= PH2_LAST;
			ph3_q   <= PH3_LAST;
			ph4_q   <= PH4_LAST;
			ph10_q  <= PH10_LAST;
		end else if (upd_en) begin
			start_q <= start_d;
			pmin_q  <= pmin_d;
			pmax_q  <= pmax_d;
			emin_q  <= emin_d;
			emax_q  <= emax_d;
			first_q <= first_d;
			ph2_q   <= ph2_d;
			ph3_q   <= ph3_d;
			ph4_q   <= ph4_d;
			ph10_q  <= ph10_d;
		end
	end

	// results reflect the state after this item
	assign flags.due    = due;
	assign flags.second = (ph2_d == 1'b0);
	assign flags.third  = (ph3_d == 2'd0);
	assign flags.fourth = (ph4_d == 2'd0);
	assign flags.tenth  = (ph10_d == 4'd0);

	assign stats.period_min = STAT_W'(pmin_d);
	assign stats.period_max = STAT_W'(pmax_d);
	assign stats.exec_min   = STAT_W'(emin_d);
	assign stats.exec_max   = STAT_W'(emax_d);
	assign stats.first_exec = STAT_W'(first_d);

endmodule

>>> design/loop_period_scheduler_stats.sv
// loop period scheduler with timing statistics. each input item is a mode and
// a free-running microsecond timestamp; every item gives exactly one result
// item. a period check starts a new base period once loop_time microseconds
// have passed (modular subtraction), advances the divide-by-2/3/4/10 phase
// flags and tracks min/max period length; an execution end tracks min/max
// execution time (the first nonzero sample is held in first_exec and kept out
// of exec_max); a restart sets the period start and clears all statistics.
// rate: one item per clock while results are taken as they come. an item passes
// an input register, then the single update stage that reads and writes the
// scheduler state and loads the result register, which drives out_valid.
// the result register lets a new item enter while a result waits to be taken.
// loop_time is written through cfg_wr_en/cfg_wr_data; the user must write it only
// while idle, which the block itself does not enforce. it resets to 10000.
module loop_period_scheduler_stats import lps_pkg::*; #(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_wr_en,
	input  logic [LOOP_W-1:0] cfg_wr_data,
	// input channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [MODE_W-1:0] mode,
	input  logic [31:0]       now_us,
	// result channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic              period_due,
	output logic              every_second,
	output logic              every_third,
	output logic              every_fourth,
	output logic              every_tenth,
	output logic [STAT_W-1:0] period_min,
	output logic [STAT_W-1:0] period_max,
	output logic [STAT_W-1:0] exec_min,
	output logic [STAT_W-1:0] exec_max,
	output logic [STAT_W-1:0] first_exec
);

	logic [LOOP_W-1:0] loop_time_q;

	// input register
	logic              valid_s1;
	logic [MODE_W-1:0] mode_s1;
	logic [31:0]       now_s1;

	// result register
	logic              valid_s2;
	lps_flags_t        flags_s2;
	lps_stats_t        stats_s2;

	lps_flags_t        flags_nxt;
	lps_stats_t        stats_nxt;
	logic              adv_s1;

	// stage 1 moves on when the result slot is empty or being drained
	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_time_q <= LOOP_TIME_RST;
		end else if (cfg_wr_en) begin
			loop_time_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= mode;
			now_s1  <= now_us;
		end
		if (adv_s1) begin
			flags_s2 <= flags_nxt;
			stats_s2 <= stats_nxt;
		end
	end

	// state update happens exactly once per item, as it leaves stage 1
	lps_core #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd_en   (adv_s1),
		.mode     (mode_s1),
		.now_us   (now_s1),
		.loop_time(loop_time_q),
		.flags    (flags_nxt),
		.stats    (stats_nxt)
	);

	assign out_valid    = valid_s2;
	assign period_due   = flags_s2.due;
	assign every_second = flags_s2.second;
	assign every_third  = flags_s2.third;
	assign every_fourth = flags_s2.fourth;
	assign every_tenth  = flags_s2.tenth;
	assign period_min   = stats_s2.period_min;
	assign period_max   = stats_s2.period_max;
	assign exec_min     = stats_s2.exec_min;
	assign exec_max     = stats_s2.exec_max;
	assign first_exec   = stats_s2.first_exec;

	// input side only stalls when both stages are full and the output stalls
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && !out_ready))
		else $error("in_ready low without a full pipeline stall");

	// phase counters advance together, so divide-by-4 zero implies divide-by-2 zero
	a_phase_four: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && every_fourth) |-> every_second)
		else $error("every_fourth set without every_second");

	a_phase_ten: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && every_tenth) |-> every_second)
		else $error("every_tenth set without every_second");

	// a result slot that is filled must have come from stage 1
	a_fill_src: assert property (@(posedge clk) disable iff (!arst_n)
		(!$past(valid_s1) && $past(arst_n)) |-> (valid_s2 == ($past(valid_s2) && !$past(out_ready))))
		else $error("result register loaded without an item in stage 1");

endmodule

>>> test/tb_loop_period_scheduler_stats.sv
module tb_loop_period_scheduler_stats;
	import lps_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// mode code that the block must treat as a no-op
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 400000;
	// settle wait after the two-stage pipe has drained
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned MAX_PRINTED = 40;

	// one result item: flags first, then the statistics, same order as the ports
	typedef struct packed {
		lps_flags_t flags;
		lps_stats_t stats;
	} sched_result_t;

	// scoreboard: tracks the scheduler state and holds the results still to come
	class sched_scoreboard;
		logic [LOOP_W-1:0] loop_time;
		logic [31:0]       period_start;
		logic              ph2;
		logic [1:0]        ph3;
		logic [1:0]        ph4;
		logic [3:0]        ph10;
		lps_stats_t        stats;
		sched_result_t     pending_results[$];
		int                n_items;
		int                n_results;
		int                n_due;
		int                n_errors;

		function new();
			loop_time = LOOP_TIME_RST;
			clear_stats(32'd0);
			n_items = 0;
			n_results = 0;
			n_due = 0;
			n_errors = 0;
		endfunction

		function void clear_stats(logic [31:0] start);
			period_start = start;
			ph2 = PH2_LAST;
			ph3 = PH3_LAST;
			ph4 = PH4_LAST;
			ph10 = PH10_LAST;
			stats.period_min = '1;
			stats.period_max = '0;
			stats.exec_min = '1;
			stats.exec_max = '0;
			stats.first_exec = '0;
		endfunction

		// work out the result of one accepted input item
		function void note_item(logic [MODE_W-1:0] m, logic [31:0] t);
			logic [31:0]   elapsed;
			sched_result_t r;
			elapsed = t - period_start;
			r.flags.due = 1'b0;
			case (lps_mode_t'(m))
			MODE_CHECK: begin
				if (elapsed >= loop_time) begin
					r.flags.due = 1'b1;
					period_start = t;
					ph2 = (ph2 == PH2_LAST) ? 1'b0 : ph2 + 1'b1;
					ph3 = (ph3 == PH3_LAST) ? 2'd0 : ph3 + 2'd1;
					ph4 = (ph4 == PH4_LAST) ? 2'd0 : ph4 + 2'd1;
					ph10 = (ph10 == PH10_LAST) ? 4'd0 : ph10 + 4'd1;
					if (elapsed < stats.period_min)
						stats.period_min = elapsed;
					if (elapsed > stats.period_max)
						stats.period_max = elapsed;
				end
			end
			MODE_EXEC: begin
				if (elapsed < stats.exec_min)
					stats.exec_min = elapsed;
				// first nonzero sample is held apart and kept out of the max
				if (stats.first_exec == 0)
					stats.first_exec = elapsed;
				else if (elapsed > stats.exec_max)
					stats.exec_max = elapsed;
			end
			MODE_RESTART: begin
				clear_stats(t);
			end
			default: begin
			end
			endcase
			r.flags.second = (ph2 == 0);
			r.flags.third = (ph3 == 0);
			r.flags.fourth = (ph4 == 0);
			r.flags.tenth = (ph10 == 0);
			r.stats = stats;
			pending_results.push_back(r);
			n_items++;
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			if (n_errors < MAX_PRINTED)
				$display("%0t ns: result %0d: %s got 0x%08h want 0x%08h",
					$time, n_results, what, got, want);
			n_errors++;
		endtask

		task compare_field(string what, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report_mismatch(what, got, want);
		endtask

		task check_result(sched_result_t got);
			sched_result_t want;
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", 32'd0, 32'd0);
				return;
			end
			want = pending_results.pop_front();
			compare_field("period_due", got.flags.due, want.flags.due);
			compare_field("every_second", got.flags.second, want.flags.second);
			compare_field("every_third", got.flags.third, want.flags.third);
			compare_field("every_fourth", got.flags.fourth, want.flags.fourth);
			compare_field("every_tenth", got.flags.tenth, want.flags.tenth);
			compare_field("period_min", got.stats.period_min, want.stats.period_min);
			compare_field("period_max", got.stats.period_max, want.stats.period_max);
			compare_field("exec_min", got.stats.exec_min, want.stats.exec_min);
			compare_field("exec_max", got.stats.exec_max, want.stats.exec_max);
			compare_field("first_exec", got.stats.first_exec, want.stats.first_exec);
			if (want.flags.due)
				n_due++;
			n_results++;
		endtask
	endclass

	// every block input starts at a known value
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [LOOP_W-1:0] cfg_wr_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [MODE_W-1:0] mode = '0;
	logic [31:0]       now_us = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              period_due;
	logic              every_second;
	logic              every_third;
	logic              every_fourth;
	logic              every_tenth;
	logic [STAT_W-1:0] period_min;
	logic [STAT_W-1:0] period_max;
	logic [STAT_W-1:0] exec_min;
	logic [STAT_W-1:0] exec_max;
	logic [STAT_W-1:0] first_exec;

	sched_scoreboard sb;

	// sender state: burst bookkeeping and the running microsecond clock
	int unsigned burst_left = 0;
	logic [31:0] t_cur = '0;
	int          n_settings = 0;
	// set by the main flow, picked up by the receiver for one long hold-off
	bit          hold_request = 1'b0;

	loop_period_scheduler_stats u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.now_us       (now_us),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.period_due   (period_due),
		.every_second (every_second),
		.every_third  (every_third),
		.every_fourth (every_fourth),
		.every_tenth  (every_tenth),
		.period_min   (period_min),
		.period_max   (period_max),
		.exec_min     (exec_min),
		.exec_max     (exec_max),
		.first_exec   (first_exec)
	);

	always #10 clk = ~clk;

	// offer one item and hold it until accepted; bursts with random gaps between
	task automatic send_item(input logic [MODE_W-1:0] m, input logic [31:0] t);
		int unsigned gap;
		if (burst_left == 0) begin
			// a quarter of the bursts follow straight on, the rest after a gap
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		in_valid <= 1'b1;
		mode <= m;
		now_us <= t;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_item(m, t);
		burst_left--;
	endtask

	// stop offering and wait until every result is back and the pipe is empty
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// loop_time is only written with the block idle
	task automatic write_loop_time(input logic [LOOP_W-1:0] value);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.loop_time = value;
		n_settings++;
	endtask

	// mostly well-formed loop traffic on a running clock, with some noise:
	// period checks advance time by up to step_max, execution ends land
	// shortly after, the odd restart, unused mode code and random items
	task automatic run_traffic(input int count, input logic [31:0] step_max);
		int unsigned pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				t_cur = t_cur + $urandom_range(0, step_max);
				send_item(MODE_CHECK, t_cur);
			end else if (pick < 80) begin
				send_item(MODE_EXEC, t_cur + $urandom_range(0, step_max / 4));
			end else if (pick < 83) begin
				t_cur = t_cur + $urandom_range(0, step_max);
				send_item(MODE_RESTART, t_cur);
			end else if (pick < 85) begin
				send_item(MODE_UNUSED, $urandom);
			end else begin
				send_item(MODE_W'($urandom_range(0, 3)), $urandom);
			end
		end
	endtask

	// receiver: checks every accepted result, stalls on a changing pattern
	initial begin
		int unsigned rx_style;
		int unsigned rx_tick;
		int unsigned hold_left;
		rx_style = 0;
		rx_tick = 0;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result({period_due, every_second, every_third, every_fourth,
					every_tenth, period_min, period_max, exec_min, exec_max, first_exec});
			rx_tick++;
			if (rx_tick % 50 == 0)
				rx_style = $urandom_range(0, 3);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				// long hold-off so the pipe fills and in_ready drops
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (rx_style)
				0: out_ready <= 1'b1;
				1: out_ready <= $urandom_range(0, 1);
				2: out_ready <= (rx_tick % 4 == 0);
				default: out_ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	// watchdog
	initial begin
		int unsigned cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d results outstanding",
					cycles, sb.pending_results.size());
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset loop time of 10000 us
		send_item(MODE_CHECK, 32'd0);               // nothing elapsed, not due
		send_item(MODE_EXEC, 32'd0);                // zero sample leaves first_exec at zero
		send_item(MODE_EXEC, 32'd500);              // becomes first_exec
		send_item(MODE_EXEC, 32'd700);              // first sample for exec_max
		send_item(MODE_CHECK, 32'd10000);           // first period, all flags set
		send_item(MODE_CHECK, 32'd19999);           // one us short
		send_item(MODE_CHECK, 32'd20000);           // exactly on time
		send_item(MODE_UNUSED, 32'hFFFF_FFFF);      // no state change
		send_item(MODE_CHECK, 32'hFFFF_FFFF);       // top of the time range
		send_item(MODE_CHECK, 32'd9999);            // due across the wrap
		send_item(MODE_RESTART, 32'hFFFF_FFF0);     // clear just below the wrap
		send_item(MODE_CHECK, 32'h0000_2700);       // 10000 us across the wrap
		send_item(MODE_EXEC, 32'hFFFF_FFFF);        // huge execution time
		// walk the divide-by-ten phase all the way round
		for (int k = 1; k <= 10; k++)
			send_item(MODE_CHECK, 32'h0000_2700 + k * 10000);
		send_item(MODE_RESTART, 32'd0);

		// smallest loop times, zero included: nearly every check is due
		t_cur = 32'd0;
		write_loop_time(32'd1);
		run_traffic(40, 32'd3);
		write_loop_time(32'd0);
		run_traffic(40, 32'd3);

		// largest loop time: due only one us short of a full wrap
		write_loop_time(32'hFFFF_FFFF);
		send_item(MODE_RESTART, 32'h8000_0000);
		send_item(MODE_CHECK, 32'h7FFF_FFFF);
		send_item(MODE_CHECK, 32'h7FFF_FFFE);
		t_cur = 32'h7FFF_FFFE;
		run_traffic(26, 32'hFFFF_FFFF);

		// short random loop time from a random start
		write_loop_time($urandom_range(1, 2000));
		t_cur = $urandom;
		run_traffic(230, sb.loop_time);

		// reset loop time near the wrap, receiver held off at the start
		write_loop_time(LOOP_TIME_RST);
		t_cur = 32'hFFF0_0000;
		hold_request = 1'b1;
		run_traffic(230, sb.loop_time);

		write_loop_time($urandom_range(2000, 100000));
		run_traffic(230, sb.loop_time);

		write_loop_time($urandom);
		t_cur = $urandom;
		run_traffic(230, sb.loop_time);

		drain();
		if (sb.pending_results.size() != 0)
			sb.report_mismatch("results never arrived", sb.pending_results.size(), 0);

		$display("covered %0d items and %0d results, %0d new periods, %0d loop times",
			sb.n_items, sb.n_results, sb.n_due, n_settings + 1);
		$display("loop times 0, 1, all ones, reset and random; %0d mismatches",
			sb.n_errors);
		if (sb.n_errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
